@@ rtl/core/mexp_pkg.sv @@
// Package for the modular exponentiation block.
// Holds the sequencer state type; no dependencies.
package mexp_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REDUCE,
        ST_EXP,
        ST_MUL,
        ST_DONE
    } mexp_state_t;

endpackage

@@ rtl/core/modular_exponentiation.sv @@
// Modular exponentiation top level: base^exponent mod modulus by binary square-and-multiply.
// Depends on mexp_pkg for the sequencer state type.
//
// Channel   Direction  Handshake                  Payload
// --------  ---------  -------------------------  -----------------------------
// input     in         in_valid / in_stall        base, exponent
// output    out        out_valid / out_stall      residue
// config    in         APB psel/penable/pwrite    paddr, pwdata, prdata
//
// Steps: the base is first reduced modulo the modulus (ST_REDUCE). Each modular
// multiplication then takes a decision state (ST_EXP) and a pass through the shared
// shift-and-add unit (ST_MUL): a set exponent bit needs a multiply and a square, a clear
// bit only the square, and the square after the top set bit is skipped. A modulus of
// one or zero goes straight to the result, and a base that reduces to zero skips the
// multiplications.
// Reset (rst_n, asynchronous, active low) sets the modulus to one and empties the
// output register. in_stall is high while an item is in work; a finished residue
// waits in the accumulator while the output register is full and out_stall is high,
// and no next item is taken meanwhile.
module modular_exponentiation
    import mexp_pkg::*;
#(
    parameter int WORD_BITS = 32
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    // Configuration port
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [((WORD_BITS > 32) ? 4 : 3)-1:0] paddr,
    input  logic [((WORD_BITS > 32) ? 64 : 32)-1:0] pwdata,
    output logic [((WORD_BITS > 32) ? 64 : 32)-1:0] prdata,
    output logic                                  pready,
    // Input channel
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic [WORD_BITS-1:0]                  base,
    input  logic [WORD_BITS-1:0]                  exponent,
    // Output channel
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic [WORD_BITS-1:0]                  residue
);

    localparam int PDATA_W  = (WORD_BITS > 32) ? 64 : 32;
    localparam int ADDR_LSB = (WORD_BITS > 32) ? 3 : 2;
    localparam int ADDR_W   = ADDR_LSB + 1;
    localparam int CNT_W    = $clog2(WORD_BITS);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(WORD_BITS - 1);
    localparam logic [0:0] REG_MODULUS = 1'b0;

    mexp_state_t state_reg, state_next;

    logic [WORD_BITS-1:0] m_reg;          // configured modulus
    logic [WORD_BITS-1:0] mw_reg,   mw_next;    // modulus captured for the item in work
    logic [WORD_BITS-1:0] sq_reg,   sq_next;    // running square
    logic [WORD_BITS-1:0] acc_reg,  acc_next;   // accumulated result
    logic [WORD_BITS-1:0] exp_reg,  exp_next;   // exponent bits still to scan
    logic [WORD_BITS-1:0] mop_reg,  mop_next;   // multiplier operand, scanned MSB first
    logic [WORD_BITS-1:0] prod_reg, prod_next;  // partial product or partial remainder
    logic [CNT_W-1:0]     cnt_reg,  cnt_next;
    logic                 tgt_acc_reg, tgt_acc_next;
    logic [WORD_BITS-1:0] residue_reg, residue_next;
    logic                 out_valid_reg, out_valid_next;

    logic [0:0]           cfg_index;
    logic                 cfg_wr;
    logic                 trivial;
    logic                 out_load;

    // Shared unit: one doubling step with a shifted-in bit, then an optional add,
    // each followed by a conditional subtract of the modulus.
    logic                 shift_in;
    logic                 add_en;
    logic [WORD_BITS:0]   dbl;
    logic [WORD_BITS:0]   dbl_red;
    logic [WORD_BITS-1:0] step1;
    logic [WORD_BITS:0]   sum;
    logic [WORD_BITS:0]   sum_red;
    logic [WORD_BITS-1:0] step2;

    // ------------------------------------------------------------------
    // Configuration port
    // ------------------------------------------------------------------
    assign cfg_index = paddr[ADDR_W-1:ADDR_LSB];
    assign cfg_wr    = psel && penable && pwrite;
    assign pready    = 1'b1;
    assign prdata    = (cfg_index == REG_MODULUS) ? PDATA_W'(m_reg) : '0;

    // A modulus of zero or one makes every residue zero.
    assign trivial   = (m_reg <= WORD_BITS'(1));

    // ------------------------------------------------------------------
    // Shared arithmetic unit
    // ------------------------------------------------------------------
    assign shift_in = (state_reg == ST_REDUCE) && mop_reg[WORD_BITS-1];
    assign add_en   = (state_reg == ST_MUL) && mop_reg[WORD_BITS-1];

    assign dbl      = {prod_reg, shift_in};
    assign dbl_red  = (dbl >= {1'b0, mw_reg}) ? (dbl - {1'b0, mw_reg}) : dbl;
    assign step1    = dbl_red[WORD_BITS-1:0];
    assign sum      = {1'b0, step1} + (add_en ? {1'b0, sq_reg} : '0);
    assign sum_red  = (sum >= {1'b0, mw_reg}) ? (sum - {1'b0, mw_reg}) : sum;
    assign step2    = sum_red[WORD_BITS-1:0];

    assign out_load = (state_reg == ST_DONE) && (!out_valid_reg || !out_stall);

    // ------------------------------------------------------------------
    // Sequencer: next state
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = trivial ? ST_DONE : ST_REDUCE;
                end
            end
            ST_REDUCE:
            begin
                if (cnt_reg == '0)
                begin
                    state_next = (step2 == '0) ? ST_DONE : ST_EXP;
                end
            end
            ST_EXP:
            begin
                state_next = (exp_reg == '0) ? ST_DONE : ST_MUL;
            end
            ST_MUL:
            begin
                if (cnt_reg == '0)
                begin
                    state_next = ST_EXP;
                end
            end
            ST_DONE:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer: datapath and outputs
    // ------------------------------------------------------------------
    always_comb
    begin
        mw_next        = mw_reg;
        sq_next        = sq_reg;
        acc_next       = acc_reg;
        exp_next       = exp_reg;
        mop_next       = mop_reg;
        prod_next      = prod_reg;
        cnt_next       = cnt_reg;
        tgt_acc_next   = tgt_acc_reg;
        residue_next   = residue_reg;
        out_valid_next = out_valid_reg && out_stall;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    // Reduction runs the base through the unit MSB first.
                    mw_next   = m_reg;
                    mop_next  = base;
                    prod_next = '0;
                    cnt_next  = CNT_LAST;
                    exp_next  = exponent;
                    acc_next  = '0;
                end
            end
            ST_REDUCE:
            begin
                prod_next = step2;
                mop_next  = mop_reg << 1;
                cnt_next  = cnt_reg - CNT_W'(1);
                if (cnt_reg == '0)
                begin
                    sq_next  = step2;
                    // A base that reduces to zero gives zero, even for a zero exponent.
                    acc_next = (step2 == '0) ? '0 : WORD_BITS'(1);
                end
            end
            ST_EXP:
            begin
                if (exp_reg != '0)
                begin
                    prod_next = '0;
                    cnt_next  = CNT_LAST;
                    if (exp_reg[0])
                    begin
                        mop_next     = acc_reg;
                        tgt_acc_next = 1'b1;
                    end
                    else
                    begin
                        mop_next     = sq_reg;
                        tgt_acc_next = 1'b0;
                    end
                end
            end
            ST_MUL:
            begin
                prod_next = step2;
                mop_next  = mop_reg << 1;
                cnt_next  = cnt_reg - CNT_W'(1);
                if (cnt_reg == '0)
                begin
                    if (tgt_acc_reg)
                    begin
                        // Bit consumed by the multiply; the square follows unless no set bit is left.
                        acc_next = step2;
                        exp_next = {exp_reg[WORD_BITS-1:1], 1'b0};
                    end
                    else
                    begin
                        sq_next  = step2;
                        exp_next = exp_reg >> 1;
                    end
                end
            end
            ST_DONE:
            begin
                if (out_load)
                begin
                    residue_next   = acc_reg;
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
                out_valid_next = 1'b0;
            end
        endcase
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign residue   = residue_reg;

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            m_reg         <= WORD_BITS'(1);
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr && (cfg_index == REG_MODULUS))
            begin
                m_reg <= pwdata[WORD_BITS-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        mw_reg      <= mw_next;
        sq_reg      <= sq_next;
        acc_reg     <= acc_next;
        exp_reg     <= exp_next;
        mop_reg     <= mop_next;
        prod_reg    <= prod_next;
        cnt_reg     <= cnt_next;
        tgt_acc_reg <= tgt_acc_next;
        residue_reg <= residue_next;
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
`ifndef NO_ASSERTIONS
    // The partial result and the square always stay below the captured modulus.
    a_mul_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MUL) |-> ((prod_reg < mw_reg) && (sq_reg < mw_reg)))
        else $error("multiplier operand not reduced");

    // An accepted item starts either the reduction or the trivial result.
    a_accept_start: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> ((state_reg == ST_REDUCE) || (state_reg == ST_DONE)))
        else $error("accepted item did not start");

    // A finished result is held while the output register is still occupied.
    a_done_holds: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_DONE) && out_valid_reg && out_stall) |=> (state_reg == ST_DONE))
        else $error("finished result dropped while output stalled");
`endif

endmodule

@@ tb/sv/tb.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for the modular exponentiation block: operands in, residues out.
// Depends only on the modular_exponentiation RTL and its package; nothing is read from disk.

module tb;

    // ------------------------------------------------------------------
    // Configuration of the environment
    // ------------------------------------------------------------------
    localparam int WORD_BITS  = 32;
    localparam int CLK_PERIOD = 10;

    // Register map: the modulus is the only register, at byte address 0.
    // Address 4 lies beyond the map and must be ignored by the block.
    localparam bit [2:0] MODULUS_ADDR  = 3'd0;
    localparam bit [2:0] UNMAPPED_ADDR = 3'd4;

    // The settle time at the end and the long output hold are both sized from
    // the worst case latency of the block.
    localparam int SETTLE_CYCLES    = 2400;
    localparam int LONG_HOLD_CYCLES = 5000;
    localparam int TIMEOUT_NS       = 50_000_000;
    localparam int MAX_PRINTED      = 30;

    // One operand pair waiting to be sent, with the idle gap placed before it.
    typedef struct {
        bit [WORD_BITS-1:0] base_val;
        bit [WORD_BITS-1:0] exp_val;
        int unsigned        gap;
    } operand_pair_t;

    // One residue the block still owes, kept with its operands for messages.
    typedef struct {
        bit [WORD_BITS-1:0] base_val;
        bit [WORD_BITS-1:0] exp_val;
        bit [WORD_BITS-1:0] modulus_val;
        bit [WORD_BITS-1:0] residue_val;
    } owed_residue_t;

    // ------------------------------------------------------------------
    // Signals of the block; every input starts at a known value.
    // ------------------------------------------------------------------
    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 psel      = 1'b0;
    logic                 penable   = 1'b0;
    logic                 pwrite    = 1'b0;
    logic [2:0]           paddr     = '0;
    logic [31:0]          pwdata    = '0;
    logic [31:0]          prdata;
    logic                 pready;
    logic                 in_valid  = 1'b0;
    logic                 in_stall;
    logic [WORD_BITS-1:0] base      = '0;
    logic [WORD_BITS-1:0] exponent  = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic [WORD_BITS-1:0] residue;

    // ------------------------------------------------------------------
    // Testbench state
    // ------------------------------------------------------------------
    operand_pair_t      queued_operands[$];
    owed_residue_t      pending_residues[$];
    operand_pair_t      next_pair;
    owed_residue_t      issued_residue;
    owed_residue_t      oldest_residue;
    bit [WORD_BITS-1:0] modulus_setting = 1;    // the block's modulus after reset
    int unsigned        send_wait       = 0;
    int unsigned        recv_wait       = 0;
    int unsigned        hold_left       = 0;
    int unsigned        pairs_queued    = 0;
    int unsigned        items_sent      = 0;
    int unsigned        results_seen    = 0;
    int unsigned        modulus_writes  = 0;
    int unsigned        error_count     = 0;

    modular_exponentiation #(
        .WORD_BITS(WORD_BITS)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .base      (base),
        .exponent  (exponent),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .residue   (residue)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // ------------------------------------------------------------------
    // Prediction and reporting
    // ------------------------------------------------------------------

    // Right-to-left square-and-multiply. Both factors stay below the modulus,
    // so every product fits in 64 bits and the remainder is exact. A modulus
    // of zero or one yields zero, and so does a base that reduces to zero,
    // even when the exponent is zero.
    function automatic bit [WORD_BITS-1:0] expected_power(input bit [WORD_BITS-1:0] b,
                                                          input bit [WORD_BITS-1:0] e,
                                                          input bit [WORD_BITS-1:0] m);
        bit [63:0] square;
        bit [63:0] product;
        if (m <= 1)
            return '0;
        square = b % m;
        if (square == 0)
            return '0;
        product = 1;
        for (int i = 0; i < WORD_BITS; i++)
        begin
            if (e[i])
                product = (product * square) % m;
            square = (square * square) % m;
        end
        return product[WORD_BITS-1:0];
    endfunction

    // Every failure goes through here: it is counted, and the first few are printed.
    task automatic report_mismatch(input string what);
        error_count++;
        if (error_count <= MAX_PRINTED)
            $display("[%0t] MISMATCH: %s", $time, what);
    endtask

    // ------------------------------------------------------------------
    // Input driver. It records the expected residue for each transfer and
    // then offers the next operand pair once that pair's gap has passed.
    // A stalled pair is held unchanged until the block takes it.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                issued_residue.base_val    = base;
                issued_residue.exp_val     = exponent;
                issued_residue.modulus_val = modulus_setting;
                issued_residue.residue_val = expected_power(base, exponent, modulus_setting);
                pending_residues.push_back(issued_residue);
                items_sent++;
            end
            if (!in_valid || !in_stall)
            begin
                if (queued_operands.size() == 0)
                begin
                    in_valid <= 1'b0;
                end
                else if (send_wait < queued_operands[0].gap)
                begin
                    send_wait++;
                    in_valid <= 1'b0;
                end
                else
                begin
                    next_pair = queued_operands.pop_front();
                    send_wait = 0;
                    in_valid <= 1'b1;
                    base     <= next_pair.base_val;
                    exponent <= next_pair.exp_val;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Output monitor. Each transfer is checked against the oldest owed
    // residue. After each transfer it draws how many cycles to keep the
    // next result waiting; some stretches draw no wait at all. Twice in the
    // run it holds the output off long enough that the block fills and
    // stalls its input while the driver keeps offering pairs.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (pending_residues.size() == 0)
                begin
                    report_mismatch($sformatf("residue %h arrived with nothing owed", residue));
                end
                else
                begin
                    oldest_residue = pending_residues.pop_front();
                    if (residue !== oldest_residue.residue_val)
                        report_mismatch($sformatf(
                            "%h^%h mod %h: residue %h, expected %h",
                            oldest_residue.base_val, oldest_residue.exp_val,
                            oldest_residue.modulus_val, residue,
                            oldest_residue.residue_val));
                end
                results_seen++;
                recv_wait = ((results_seen % 48) < 12) ? 0 : $urandom_range(0, 4);
                if (results_seen == 40 || results_seen == 200)
                    hold_left = LONG_HOLD_CYCLES;
            end
            else if (out_valid && recv_wait > 0)
            begin
                recv_wait--;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= (recv_wait > 0);
            end
        end
    end

    // ------------------------------------------------------------------
    // Configuration port and stimulus helpers
    // ------------------------------------------------------------------

    // One APB transfer: setup cycle, then access cycle until pready.
    // It returns at a falling edge, so callers never race the clocked blocks.
    task automatic apb_access(input bit is_write, input bit [2:0] addr,
                              input bit [31:0] wdata, output bit [31:0] rdata);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= is_write;
        paddr   <= addr;
        pwdata  <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
        if (is_write && addr == MODULUS_ADDR)
        begin
            modulus_setting = wdata;
            modulus_writes++;
        end
    endtask

    task automatic check_modulus_readback();
        bit [31:0] readback;
        apb_access(1'b0, MODULUS_ADDR, '0, readback);
        if (readback !== modulus_setting)
            report_mismatch($sformatf("modulus reads back %h, expected %h",
                                      readback, modulus_setting));
    endtask

    task automatic set_modulus(input bit [31:0] value);
        bit [31:0] unused;
        apb_access(1'b1, MODULUS_ADDR, value, unused);
        check_modulus_readback();
    endtask

    // Queues a pair. The gap before it is random, except in every third
    // run of twelve pairs, which goes out back to back.
    task automatic queue_operands(input bit [WORD_BITS-1:0] b, input bit [WORD_BITS-1:0] e);
        operand_pair_t pair;
        pair.base_val = b;
        pair.exp_val  = e;
        pair.gap      = ((pairs_queued / 12) % 3 == 0) ? 0 : $urandom_range(0, 4);
        queued_operands.push_back(pair);
        pairs_queued++;
    endtask

    // Blocks until the driver is empty and every owed residue has arrived.
    task automatic wait_for_drain();
        do
            @(negedge clk);
        while (queued_operands.size() != 0 || in_valid || pending_residues.size() != 0);
    endtask

    // Bases favor the interesting spots around the modulus: the modulus
    // itself and its multiples reduce to zero, one below it is minus one.
    function automatic bit [WORD_BITS-1:0] pick_base(input bit [WORD_BITS-1:0] m);
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            2: return m;
            3: return m * $urandom_range(2, 5);
            4: return m - $urandom_range(1, 3);
            5: return m + $urandom_range(1, 3);
            6: return $urandom_range(0, 15);
            default: return $urandom;
        endcase
    endfunction

    // Exponents are most often full random words, with zero, one, small values,
    // single bits, sparse words and all ones mixed in.
    function automatic bit [WORD_BITS-1:0] pick_exponent();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return 1;
            2: return $urandom_range(2, 64);
            3: return '1;
            4: return 32'd1 << $urandom_range(0, 31);
            5: return $urandom & $urandom;
            default: return $urandom;
        endcase
    endfunction

    task automatic run_random_phase(input bit [31:0] m, input int count);
        set_modulus(m);
        for (int i = 0; i < count; i++)
            queue_operands(pick_base(m), pick_exponent());
        wait_for_drain();
    endtask

    // ------------------------------------------------------------------
    // Main sequence. Each phase ends with the sender paused until every
    // owed residue is back, and only then is the modulus changed.
    // ------------------------------------------------------------------
    initial
    begin
        bit [31:0] unused;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // The modulus comes out of reset as one, so every residue is zero.
        check_modulus_readback();
        queue_operands(32'h0000_0000, 32'h0000_0000);
        queue_operands(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        queue_operands(32'h0000_3039, 32'h0000_0003);
        wait_for_drain();

        // A modulus of zero behaves like a modulus of one.
        set_modulus(32'h0000_0000);
        queue_operands(32'h0000_0007, 32'h0000_0000);
        queue_operands(32'hFFFF_FFFF, 32'h0000_0005);
        wait_for_drain();

        // Largest 32-bit prime. A write beyond the register map must leave it alone.
        set_modulus(32'hFFFF_FFFB);
        apb_access(1'b1, UNMAPPED_ADDR, 32'h0000_0007, unused);
        check_modulus_readback();
        queue_operands(32'h0000_0000, 32'h0000_0000);   // zero base, zero exponent
        queue_operands(32'h0000_0000, 32'hFFFF_FFFF);
        queue_operands(32'h0000_0005, 32'h0000_0000);   // zero exponent gives one
        queue_operands(32'hFFFF_FFFB, 32'h0000_0000);   // base reduces to zero
        queue_operands(32'hFFFF_FFFB, 32'h0000_0007);
        queue_operands(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        queue_operands(32'hFFFF_FFFC, 32'hFFFF_FFFF);   // base reduces to one
        queue_operands(32'h0000_0002, 32'h0000_001F);
        queue_operands(32'h0000_0002, 32'h0000_0020);
        queue_operands(32'hAAAA_AAAA, 32'h5555_5555);
        queue_operands(32'h5555_5555, 32'hAAAA_AAAA);
        queue_operands(32'hFFFF_FFFA, 32'h0000_0002);   // minus one squared
        queue_operands(32'h0000_0003, 32'h0000_0001);
        wait_for_drain();

        // Largest modulus.
        set_modulus(32'hFFFF_FFFF);
        queue_operands(32'hFFFF_FFFF, 32'h0000_0003);
        queue_operands(32'hFFFF_FFFE, 32'hFFFF_FFFF);
        queue_operands(32'h8000_0000, 32'hFFFF_FFFE);
        wait_for_drain();

        // Smallest modulus that does real work.
        set_modulus(32'h0000_0002);
        queue_operands(32'h0000_0003, 32'hFFFF_FFFF);
        queue_operands(32'h0000_0004, 32'h0000_0001);
        queue_operands(32'h0000_0001, 32'h0000_0000);
        wait_for_drain();

        // Random phases. The first is fast, so the first long output hold
        // fills the block quickly; the second hold lands in a slow phase.
        run_random_phase(32'h0000_0001, 30);
        run_random_phase(32'hFFFF_FFFF, 40);
        run_random_phase($urandom | 32'h8000_0000, 45);
        run_random_phase($urandom_range(2, 300), 40);
        run_random_phase($urandom_range(2, 32'hFFFF_FFFF), 45);
        run_random_phase(32'hFFFF_FFFB, 45);

        // Anything the block sends after this point has no owner and fails.
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Summary: %0d operand pairs in, %0d residues out, %0d modulus writes.",
                 items_sent, results_seen, modulus_writes);
        $display("Moduli spanned zero, one, two and all ones, with two long output holds.");
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Watchdog: several times the slowest correct run.
    initial
    begin
        #(TIMEOUT_NS);
        $display("Timeout with %0d residues still owed", pending_residues.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/core/mexp_pkg.sv
rtl/core/modular_exponentiation.sv
tb/sv/tb.sv
